// ===== rtl/dmwc_pkg.sv =====
// Shared types and constants for the direct-mapped write-back cache.
// Used by dmwc_front, dmwc_back and the top module; depends on nothing.
package dmwc_pkg;

   localparam int ADDR_W          = 32;
   localparam int DATA_W          = 32;
   localparam int CFG_W           = 16;
   localparam int COST_W          = 32;
   localparam int LINE_COUNT      = 256;
   localparam int WORDS_PER_BLOCK = 16;
   localparam int MEMORY_WORDS    = 16384;
   localparam int BYTE_SEL_W      = 2;
   localparam int IDX_W           = $clog2(LINE_COUNT);
   localparam int WIB_W           = $clog2(WORDS_PER_BLOCK);
   localparam int MEM_AW          = $clog2(MEMORY_WORDS);
   localparam int TAG_W           = MEM_AW - WIB_W - IDX_W;
   localparam int CACHE_AW        = IDX_W + WIB_W;
   localparam int CSR_IDX_W       = 2;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_READ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_WRITE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_READ  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_WRITE = 2'd3;

   // classified item as queued between front and back
   typedef struct packed {
      op_type              op;
      logic                oor;
      logic [TAG_W-1:0]    tag;
      logic [IDX_W-1:0]    idx;
      logic [WIB_W-1:0]    wib;
      logic [DATA_W-1:0]   wdata;
   } job_type;

   // back to front handshake
   typedef struct packed {
      logic pop;
      logic ready;
   } back_ctl_type;

endpackage

// ===== rtl/dmwc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dmwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dmwc_front.sv =====
// Front end: accepts items, splits and range-checks the address, queues them.
// Depends on dmwc_pkg.
module dmwc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [dmwc_pkg::ADDR_W-1:0]   req_address,
   input  logic [dmwc_pkg::DATA_W-1:0]   req_write_data,
   input  dmwc_pkg::back_ctl_type        back_ctl,
   output logic                          q_valid,
   output dmwc_pkg::job_type             q_job
);
   import dmwc_pkg::*;

   job_type    job;
   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // classify the item
   always_comb begin
      job.op    = op_type'(req_op);
      job.oor   = (req_address[ADDR_W-1:MEM_AW+BYTE_SEL_W] != '0) &&
                  (job.op == OP_READ || job.op == OP_WRITE);
      job.tag   = req_address[MEM_AW+BYTE_SEL_W-1:IDX_W+WIB_W+BYTE_SEL_W];
      job.idx   = req_address[IDX_W+WIB_W+BYTE_SEL_W-1:WIB_W+BYTE_SEL_W];
      job.wib   = req_address[WIB_W+BYTE_SEL_W-1:BYTE_SEL_W];
      job.wdata = req_write_data;
   end

   assign req_ready = back_ctl.ready && (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = back_ctl.pop && (count_ff != 2'd0);
   assign q_valid   = (count_ff != 2'd0);
   assign q_job     = slot_ff[rd_ptr_ff];

   // two-entry item queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= job;
      end
   end

endmodule

// ===== rtl/dmwc_back.sv =====
// Back end: sequencer for lookup, victim writeback, block fill and word access;
// owns tag, cache and backing memories, cost counter and result register.
// Depends on dmwc_pkg and dmwc_ram.
module dmwc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [dmwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmwc_pkg::CFG_W-1:0]     csr_write_data,
   input  logic                           q_valid,
   input  dmwc_pkg::job_type              q_job,
   output dmwc_pkg::back_ctl_type         back_ctl,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dmwc_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                           rsp_hit,
   output logic                           rsp_wrote_back,
   output logic                           rsp_out_of_range,
   output logic [dmwc_pkg::COST_W-1:0]    rsp_total_cost
);
   import dmwc_pkg::*;

   typedef enum logic [7:0] {
      S_INIT = 8'b0000_0001,
      S_IDLE = 8'b0000_0010,
      S_LOOK = 8'b0000_0100,
      S_WB   = 8'b0000_1000,
      S_FILL = 8'b0001_0000,
      S_ACC  = 8'b0010_0000,
      S_RD   = 8'b0100_0000,
      S_RESP = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [WIB_W:0]       cnt_ff, cnt_in;
   logic [MEM_AW-1:0]    clr_ff, clr_in;
   logic [TAG_W-1:0]     vtag_ff, vtag_in;
   logic                 hit_ff, hit_in;
   logic                 wb_ff, wb_in;
   logic                 oor_ff, oor_in;
   logic [DATA_W-1:0]    rdata_ff, rdata_in;
   logic [COST_W-1:0]    cost_ff, cost_in;
   logic [CFG_W-1:0]     mrc_ff, mwc_ff, hrc_ff, hwc_ff;
   logic [LINE_COUNT-1:0] valid_ff, valid_in;
   logic [LINE_COUNT-1:0] dirty_ff, dirty_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_rdata_ff;
   logic                 rsp_hit_ff, rsp_wb_ff, rsp_oor_ff;
   logic [COST_W-1:0]    rsp_cost_ff;
   logic                 load_rsp;
   logic                 last;

   logic                 tag_we;
   logic [TAG_W-1:0]     tag_rdata;
   logic                 cache_we;
   logic [CACHE_AW-1:0]  cache_waddr, cache_raddr;
   logic [DATA_W-1:0]    cache_wdata, cache_rdata;
   logic                 back_we;
   logic [MEM_AW-1:0]    back_waddr, back_raddr;
   logic [DATA_W-1:0]    back_wdata, back_rdata;

   dmwc_ram #(.WIDTH(TAG_W), .DEPTH(LINE_COUNT)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (job_ff.idx),
      .wdata (job_ff.tag),
      .raddr (q_job.idx),
      .rdata (tag_rdata)
   );

   dmwc_ram #(.WIDTH(DATA_W), .DEPTH(LINE_COUNT*WORDS_PER_BLOCK)) u_cache_ram (
      .clock (clock),
      .we    (cache_we),
      .waddr (cache_waddr),
      .wdata (cache_wdata),
      .raddr (cache_raddr),
      .rdata (cache_rdata)
   );

   dmwc_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_back_ram (
      .clock (clock),
      .we    (back_we),
      .waddr (back_waddr),
      .wdata (back_wdata),
      .raddr (back_raddr),
      .rdata (back_rdata)
   );

   assign last     = (cnt_ff == (WIB_W+1)'(WORDS_PER_BLOCK));
   assign load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // memory port steering
   always_comb begin
      logic [WIB_W-1:0] prev;
      prev        = cnt_ff[WIB_W-1:0] - 1'b1;
      cache_raddr = (state_ff == S_WB) ? {job_ff.idx, cnt_ff[WIB_W-1:0]}
                                       : {job_ff.idx, job_ff.wib};
      cache_we    = ((state_ff == S_FILL) && (cnt_ff != '0)) ||
                    ((state_ff == S_ACC) && (job_ff.op == OP_WRITE));
      cache_waddr = (state_ff == S_FILL) ? {job_ff.idx, prev} : {job_ff.idx, job_ff.wib};
      cache_wdata = (state_ff == S_FILL) ? back_rdata : job_ff.wdata;
      back_raddr  = {job_ff.tag, job_ff.idx, cnt_ff[WIB_W-1:0]};
      back_we     = (state_ff == S_INIT) || ((state_ff == S_WB) && (cnt_ff != '0));
      back_waddr  = (state_ff == S_INIT) ? clr_ff : {vtag_ff, job_ff.idx, prev};
      back_wdata  = (state_ff == S_INIT) ? '0 : cache_rdata;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      cnt_in         = cnt_ff;
      clr_in         = clr_ff;
      vtag_in        = vtag_ff;
      hit_in         = hit_ff;
      wb_in          = wb_ff;
      oor_in         = oor_ff;
      rdata_in       = rdata_ff;
      cost_in        = cost_ff;
      valid_in       = valid_ff;
      dirty_in       = dirty_ff;
      tag_we         = 1'b0;
      back_ctl.pop   = 1'b0;
      back_ctl.ready = (state_ff != S_INIT);
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_INIT: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               back_ctl.pop = 1'b1;
               job_in       = q_job;
               hit_in       = 1'b0;
               wb_in        = 1'b0;
               rdata_in     = '0;
               oor_in       = q_job.oor;
               if ((q_job.op == OP_READ || q_job.op == OP_WRITE) && !q_job.oor) begin
                  state_in = S_LOOK;
               end else begin
                  if (q_job.op == OP_CLEAR) begin
                     cost_in = '0;
                  end
                  state_in = S_RESP;
               end
            end
         end
         S_LOOK: begin
            vtag_in = tag_rdata;
            cnt_in  = '0;
            if (valid_ff[job_ff.idx] && tag_rdata == job_ff.tag) begin
               hit_in   = 1'b1;
               state_in = S_ACC;
            end else begin
               cost_in  = cost_ff + COST_W'(mrc_ff);
               tag_we   = 1'b1;
               valid_in[job_ff.idx] = 1'b1;
               dirty_in[job_ff.idx] = 1'b0;
               if (valid_ff[job_ff.idx] && dirty_ff[job_ff.idx]) begin
                  wb_in    = 1'b1;
                  state_in = S_WB;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_WB: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               cost_in = cost_ff + COST_W'(mwc_ff);
            end
            if (last) begin
               cnt_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (job_ff.op == OP_WRITE) begin
               dirty_in[job_ff.idx] = 1'b1;
               cost_in  = cost_ff + COST_W'(hwc_ff);
               state_in = S_RESP;
            end else begin
               cost_in  = cost_ff + COST_W'(hrc_ff);
               state_in = S_RD;
            end
         end
         S_RD: begin
            rdata_in = cache_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         cost_ff      <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         mrc_ff       <= CFG_W'(100);
         mwc_ff       <= CFG_W'(50);
         hrc_ff       <= CFG_W'(1);
         hwc_ff       <= CFG_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cost_ff      <= cost_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MEM_READ:  mrc_ff <= csr_write_data;
               CSR_MEM_WRITE: mwc_ff <= csr_write_data;
               CSR_HIT_READ:  hrc_ff <= csr_write_data;
               CSR_HIT_WRITE: hwc_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      job_ff   <= job_in;
      vtag_ff  <= vtag_in;
      hit_ff   <= hit_in;
      wb_ff    <= wb_in;
      oor_ff   <= oor_in;
      rdata_ff <= rdata_in;
      if (load_rsp) begin
         rsp_rdata_ff <= rdata_ff;
         rsp_hit_ff   <= hit_ff;
         rsp_wb_ff    <= wb_ff;
         rsp_oor_ff   <= oor_ff;
         rsp_cost_ff  <= cost_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_rdata_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_wrote_back   = rsp_wb_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_total_cost   = rsp_cost_ff;

endmodule

// ===== rtl/direct_mapped_writeback_cache.sv =====
// Direct-mapped write-back, write-allocate word cache, 256 lines of 16 words,
// in front of a 16384-word backing memory. After reset the backing memory is
// zeroed one word a cycle, during which req_ready stays low. Items then run
// one at a time: a hit passes lookup and word access, and a read also a read
// stage, before the result is registered; a miss adds a block fill, and a
// dirty victim a writeback before it, each moving a word at a time over the
// single-word ports of the cache and backing memories. A two-item queue lets
// new items be taken while one is in work.
// Depends on dmwc_pkg, dmwc_front, dmwc_back and dmwc_ram.
module direct_mapped_writeback_cache (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_op,
   input  logic [dmwc_pkg::ADDR_W-1:0]    req_address,
   input  logic [dmwc_pkg::DATA_W-1:0]    req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dmwc_pkg::DATA_W-1:0]    rsp_read_data,
   output logic                           rsp_hit,
   output logic                           rsp_wrote_back,
   output logic                           rsp_out_of_range,
   output logic [dmwc_pkg::COST_W-1:0]    rsp_total_cost,
   input  logic                           csr_write_enable,
   input  logic [dmwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmwc_pkg::CFG_W-1:0]     csr_write_data
);
   import dmwc_pkg::*;

   back_ctl_type back_ctl;
   logic         q_valid;
   job_type      q_job;

   dmwc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .back_ctl       (back_ctl),
      .q_valid        (q_valid),
      .q_job          (q_job)
   );

   dmwc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_job            (q_job),
      .back_ctl         (back_ctl),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_hit          (rsp_hit),
      .rsp_wrote_back   (rsp_wrote_back),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_total_cost   (rsp_total_cost)
   );

endmodule
